### src/mck_pkg.sv
`timescale 1ns / 1ps
// Package with the shared types, constants and the character pattern table of the Morse keyer.
package mck_pkg;

	localparam int CharWidth     = 8;
	localparam int PatWidth      = 7;
	localparam int UnitsWidth    = 3;
	localparam int DotWidth      = 11;
	localparam int DurWidth      = 14;
	localparam int QDepth        = 4;
	localparam int QPtrWidth     = (QDepth > 1) ? $clog2(QDepth) : 1;
	localparam int QCntWidth     = $clog2(QDepth + 1);

	localparam logic [DotWidth-1:0]   DotReset    = DotWidth'(92);
	localparam logic [CharWidth-1:0]  CharSpace   = 8'h20;
	localparam logic [UnitsWidth-1:0] UnitsDot    = 3'd1;
	localparam logic [UnitsWidth-1:0] UnitsEnd    = 3'd2;
	localparam logic [UnitsWidth-1:0] UnitsDash   = 3'd3;
	localparam logic [UnitsWidth-1:0] UnitsWord   = 3'd7;

	typedef struct packed {
		logic                is_space;
		logic [PatWidth-1:0] pattern;
	} entry_t;

	// Returns the element pattern, LSB first with a closing sentinel bit, or zero when the
	// character has no Morse code.
	function automatic logic [PatWidth-1:0] lookup_pattern(input logic [CharWidth-1:0] ch);
		logic [PatWidth-1:0] pat;
		pat = '0;
		unique case (ch)
			8'h2B: pat = 7'd42;
			8'h2D: pat = 7'd97;
			8'h3D: pat = 7'd49;
			8'h2E: pat = 7'd106;
			8'h2C: pat = 7'd115;
			8'h3F: pat = 7'd76;
			8'h2F: pat = 7'd41;
			8'h41: pat = 7'd6;
			8'h42: pat = 7'd17;
			8'h43: pat = 7'd21;
			8'h44: pat = 7'd9;
			8'h45: pat = 7'd2;
			8'h46: pat = 7'd20;
			8'h47: pat = 7'd11;
			8'h48: pat = 7'd16;
			8'h49: pat = 7'd4;
			8'h4A: pat = 7'd30;
			8'h4B: pat = 7'd13;
			8'h4C: pat = 7'd18;
			8'h4D: pat = 7'd7;
			8'h4E: pat = 7'd5;
			8'h4F: pat = 7'd15;
			8'h50: pat = 7'd22;
			8'h51: pat = 7'd27;
			8'h52: pat = 7'd10;
			8'h53: pat = 7'd8;
			8'h54: pat = 7'd3;
			8'h55: pat = 7'd12;
			8'h56: pat = 7'd24;
			8'h57: pat = 7'd14;
			8'h58: pat = 7'd25;
			8'h59: pat = 7'd29;
			8'h5A: pat = 7'd19;
			8'h31: pat = 7'd62;
			8'h32: pat = 7'd60;
			8'h33: pat = 7'd56;
			8'h34: pat = 7'd48;
			8'h35: pat = 7'd32;
			8'h36: pat = 7'd33;
			8'h37: pat = 7'd35;
			8'h38: pat = 7'd39;
			8'h39: pat = 7'd47;
			8'h30: pat = 7'd63;
			default: pat = '0;
		endcase
		return pat;
	endfunction

endpackage

### src/mck_if.sv
`timescale 1ns / 1ps
// Stream interfaces for the character input and the segment output of the Morse keyer.
interface mck_char_if;
	logic                            valid;
	logic                            ready;
	logic [mck_pkg::CharWidth-1:0]   character;

	modport source (output valid, output character, input ready);
	modport sink (input valid, input character, output ready);
endinterface

interface mck_seg_if;
	logic                            valid;
	logic                            ready;
	logic                            key_on;
	logic [mck_pkg::UnitsWidth-1:0]  units;
	logic [mck_pkg::DurWidth-1:0]    duration_ms;
	logic                            last;

	modport source (output valid, output key_on, output units, output duration_ms,
		output last, input ready);
	modport sink (input valid, input key_on, input units, input duration_ms,
		input last, output ready);
endinterface

### src/mck_front.sv
`timescale 1ns / 1ps
// Front end: takes characters, looks up their patterns and drops characters with no code.
module mck_front (
	input  logic                clk,
	input  logic                arst_n,
	mck_char_if.sink            chars,
	output logic                push_valid,
	input  logic                push_ready,
	output mck_pkg::entry_t     push_entry
);

	logic                              valid_s1;
	mck_pkg::entry_t                   entry_s1;
	logic [mck_pkg::PatWidth-1:0]      pat;
	logic                              is_space;
	logic                              known;
	logic                              take;

	assign chars.ready = !valid_s1 || push_ready;
	assign take        = chars.valid && chars.ready;
	assign pat         = mck_pkg::lookup_pattern(chars.character);
	assign is_space    = (chars.character == mck_pkg::CharSpace);
	assign known       = is_space || (pat != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= known;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			entry_s1.is_space <= is_space;
			entry_s1.pattern  <= pat;
		end
	end

	assign push_valid = valid_s1;
	assign push_entry = entry_s1;

endmodule

### src/mck_queue.sv
`timescale 1ns / 1ps
// Short queue of classified characters between the front end and the segment sequencer.
module mck_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  mck_pkg::entry_t     push_entry,
	output logic                pop_valid,
	input  logic                pop_ready,
	output mck_pkg::entry_t     pop_entry
);

	mck_pkg::entry_t                   slots_q [mck_pkg::QDepth];
	logic [mck_pkg::QPtrWidth-1:0]     wr_ptr_q;
	logic [mck_pkg::QPtrWidth-1:0]     rd_ptr_q;
	logic [mck_pkg::QCntWidth-1:0]     count_q;
	logic                              do_push;
	logic                              do_pop;

	assign push_ready = (count_q != mck_pkg::QCntWidth'(mck_pkg::QDepth));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_entry  = slots_q[rd_ptr_q];

	function automatic logic [mck_pkg::QPtrWidth-1:0] next_ptr(
		input logic [mck_pkg::QPtrWidth-1:0] p);
		logic [mck_pkg::QPtrWidth-1:0] n;
		n = (p == mck_pkg::QPtrWidth'(mck_pkg::QDepth - 1)) ? '0 : p + 1'b1;
		return n;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

### src/mck_back.sv
`timescale 1ns / 1ps
// Back end: walks a pattern element by element and issues timed segments through an output register.
module mck_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [mck_pkg::DotWidth-1:0]       cfg_wr_data,
	input  logic                               pop_valid,
	output logic                               pop_ready,
	input  mck_pkg::entry_t                    pop_entry,
	mck_seg_if.source                          segments
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_MARK  = 5'b00010,
		ST_GAP   = 5'b00100,
		ST_END   = 5'b01000,
		ST_SPACE = 5'b10000
	} state_t;

	state_t                            state_q;
	state_t                            state_d;
	logic [mck_pkg::PatWidth-1:0]      pat_q;
	logic [mck_pkg::PatWidth-1:0]      pat_d;
	logic [mck_pkg::DotWidth-1:0]      dot_q;
	logic                              out_valid_q;
	logic                              out_key_q;
	logic [mck_pkg::UnitsWidth-1:0]    out_units_q;
	logic [mck_pkg::DurWidth-1:0]      out_dur_q;
	logic                              out_last_q;
	logic                              load_ok;
	logic                              seg_emit;
	logic                              seg_key;
	logic [mck_pkg::UnitsWidth-1:0]    seg_units;
	logic                              seg_last;
	logic [mck_pkg::PatWidth-1:0]      pat_shift;

	assign load_ok   = !out_valid_q || segments.ready;
	assign pat_shift = pat_q >> 1;

	always_comb begin
		state_d   = state_q;
		pat_d     = pat_q;
		pop_ready = 1'b0;
		seg_emit  = 1'b0;
		seg_key   = 1'b0;
		seg_units = mck_pkg::UnitsDot;
		seg_last  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				pop_ready = 1'b1;
				if (pop_valid) begin
					pat_d = pop_entry.pattern;
					if (pop_entry.is_space) begin
						state_d = ST_SPACE;
					end else if (pop_entry.pattern[mck_pkg::PatWidth-1:1] != '0) begin
						state_d = ST_MARK;
					end else begin
						state_d = ST_END;
					end
				end
			end
			ST_MARK: begin
				seg_emit  = load_ok;
				seg_key   = 1'b1;
				seg_units = pat_q[0] ? mck_pkg::UnitsDash : mck_pkg::UnitsDot;
				if (load_ok) begin
					state_d = ST_GAP;
				end
			end
			ST_GAP: begin
				seg_emit = load_ok;
				if (load_ok) begin
					pat_d   = pat_shift;
					state_d = (pat_shift[mck_pkg::PatWidth-1:1] != '0) ? ST_MARK : ST_END;
				end
			end
			ST_END: begin
				seg_emit  = load_ok;
				seg_units = mck_pkg::UnitsEnd;
				seg_last  = 1'b1;
				if (load_ok) begin
					state_d = ST_IDLE;
				end
			end
			ST_SPACE: begin
				seg_emit  = load_ok;
				seg_units = mck_pkg::UnitsWord;
				seg_last  = 1'b1;
				if (load_ok) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			dot_q       <= mck_pkg::DotReset;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				dot_q <= cfg_wr_data;
			end
			if (seg_emit) begin
				out_valid_q <= 1'b1;
			end else if (segments.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pat_q <= pat_d;
		if (seg_emit) begin
			out_key_q   <= seg_key;
			out_units_q <= seg_units;
			out_dur_q   <= mck_pkg::DurWidth'(seg_units) * mck_pkg::DurWidth'(dot_q);
			out_last_q  <= seg_last;
		end
	end

	assign segments.valid       = out_valid_q;
	assign segments.key_on      = out_key_q;
	assign segments.units       = out_units_q;
	assign segments.duration_ms = out_dur_q;
	assign segments.last        = out_last_q;

endmodule

### src/morse_character_keyer.sv
`timescale 1ns / 1ps
// Top level of the Morse keyer: front end, character queue and segment sequencer.
// A character passes the front-end register, the queue and the idle state of the sequencer
// before its first segment enters the output register. Throughput: the sequencer gives one
// segment per cycle while the output does not stall, and takes each character in its idle state.
// The front end takes a character per cycle while the four-entry queue has room.
// Reset clears all control state and sets the dot length to 92 ms.
module morse_character_keyer (
	input  logic                           clk,
	input  logic                           arst_n,
	mck_char_if.sink                       chars,
	mck_seg_if.source                      segments,
	input  logic                           cfg_wr_en,
	input  logic [mck_pkg::DotWidth-1:0]   cfg_wr_data
);

	logic              push_valid;
	logic              push_ready;
	mck_pkg::entry_t   push_entry;
	logic              pop_valid;
	logic              pop_ready;
	mck_pkg::entry_t   pop_entry;

	mck_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.chars      (chars),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	mck_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	mck_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_entry   (pop_entry),
		.segments    (segments)
	);

endmodule

### src/mck_checker.sv
`timescale 1ns / 1ps
// Checker on the segment output of the Morse keyer and its bind to the top level.
module mck_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              seg_valid,
	input  logic                              seg_ready,
	input  logic                              seg_key_on,
	input  logic [mck_pkg::UnitsWidth-1:0]    seg_units,
	input  logic                              seg_last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid && !seg_ready |=> seg_valid)
		else $error("Segment valid dropped before its transfer.");

	a_units: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid |-> (seg_units == mck_pkg::UnitsDot) || (seg_units == mck_pkg::UnitsEnd) ||
			(seg_units == mck_pkg::UnitsDash) || (seg_units == mck_pkg::UnitsWord))
		else $error("Segment length is not 1, 2, 3 or 7 units.");

	a_mark: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid && seg_key_on |-> !seg_last &&
			((seg_units == mck_pkg::UnitsDot) || (seg_units == mck_pkg::UnitsDash)))
		else $error("A mark must be a dot or a dash and never end a character.");

	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid && seg_last |-> !seg_key_on &&
			((seg_units == mck_pkg::UnitsEnd) || (seg_units == mck_pkg::UnitsWord)))
		else $error("A character must end with a closing or word gap.");

	a_after_mark: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid && seg_ready && seg_key_on ##1 seg_valid |-> !seg_key_on &&
			(seg_units == mck_pkg::UnitsDot))
		else $error("A mark must be followed by a one-unit gap.");

endmodule

bind morse_character_keyer mck_checker u_mck_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.seg_valid  (segments.valid),
	.seg_ready  (segments.ready),
	.seg_key_on (segments.key_on),
	.seg_units  (segments.units),
	.seg_last   (segments.last)
);

### test/mck_segment_checker.sv
`timescale 1ns / 1ps
// Checker for the Morse keyer: predicts the keying segments of each character and compares them.
module mck_segment_checker
	import mck_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	mck_char_if                 chars,
	mck_seg_if                  segments,
	input  logic                cfg_wr_en,
	input  logic [DotWidth-1:0] cfg_wr_data,
	output int                  fail_count,
	output int                  pending
);

	typedef struct packed {
		logic                  key_on;
		logic [UnitsWidth-1:0] units;
		logic [DurWidth-1:0]   duration_ms;
		logic                  last;
	} segment_t;

	logic [DotWidth-1:0] dot_len;
	segment_t            expected_segments[$];

	function automatic logic [PatWidth-1:0] morse_pattern(input logic [CharWidth-1:0] c);
		case (c)
			"+": return 7'd42;
			"-": return 7'd97;
			"=": return 7'd49;
			".": return 7'd106;
			",": return 7'd115;
			"?": return 7'd76;
			"/": return 7'd41;
			"A": return 7'd6;
			"B": return 7'd17;
			"C": return 7'd21;
			"D": return 7'd9;
			"E": return 7'd2;
			"F": return 7'd20;
			"G": return 7'd11;
			"H": return 7'd16;
			"I": return 7'd4;
			"J": return 7'd30;
			"K": return 7'd13;
			"L": return 7'd18;
			"M": return 7'd7;
			"N": return 7'd5;
			"O": return 7'd15;
			"P": return 7'd22;
			"Q": return 7'd27;
			"R": return 7'd10;
			"S": return 7'd8;
			"T": return 7'd3;
			"U": return 7'd12;
			"V": return 7'd24;
			"W": return 7'd14;
			"X": return 7'd25;
			"Y": return 7'd29;
			"Z": return 7'd19;
			"1": return 7'd62;
			"2": return 7'd60;
			"3": return 7'd56;
			"4": return 7'd48;
			"5": return 7'd32;
			"6": return 7'd33;
			"7": return 7'd35;
			"8": return 7'd39;
			"9": return 7'd47;
			"0": return 7'd63;
			default: return '0;
		endcase
	endfunction

	function automatic segment_t make_segment(input logic key, input logic [UnitsWidth-1:0] u,
		input logic fin);
		segment_t s;
		s.key_on      = key;
		s.units       = u;
		s.duration_ms = DurWidth'(int'(u) * int'(dot_len));
		s.last        = fin;
		return s;
	endfunction

	task automatic queue_segments(input logic [CharWidth-1:0] c);
		logic [PatWidth-1:0] pat;
		pat = morse_pattern(c);
		if (c == CharSpace) begin
			expected_segments.push_back(make_segment(1'b0, UnitsWord, 1'b1));
		end else if (pat != '0) begin
			while (pat > 1) begin
				expected_segments.push_back(make_segment(1'b1, pat[0] ? UnitsDash : UnitsDot, 1'b0));
				expected_segments.push_back(make_segment(1'b0, UnitsDot, 1'b0));
				pat = pat >> 1;
			end
			expected_segments.push_back(make_segment(1'b0, UnitsEnd, 1'b1));
		end
	endtask

	task automatic check_segment();
		segment_t want;
		if (expected_segments.size() == 0) begin
			$error("unexpected segment transfer: key_on %0d units %0d duration_ms %0d last %0d",
				segments.key_on, segments.units, segments.duration_ms, segments.last);
			fail_count++;
			return;
		end
		want = expected_segments.pop_front();
		if (segments.key_on !== want.key_on) begin
			$error("key_on: expected %0d, actual %0d", want.key_on, segments.key_on);
			fail_count++;
		end
		if (segments.units !== want.units) begin
			$error("units: expected %0d, actual %0d", want.units, segments.units);
			fail_count++;
		end
		if (segments.duration_ms !== want.duration_ms) begin
			$error("duration_ms: expected %0d, actual %0d", want.duration_ms,
				segments.duration_ms);
			fail_count++;
		end
		if (segments.last !== want.last) begin
			$error("last: expected %0d, actual %0d", want.last, segments.last);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_len = DotReset;
			expected_segments.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_wr_en)
				dot_len = cfg_wr_data;
			if (chars.valid && chars.ready)
				queue_segments(chars.character);
			if (segments.valid && segments.ready)
				check_segment();
			pending = expected_segments.size();
		end
	end

endmodule

### test/tb_morse_character_keyer.sv
`timescale 1ns / 1ps
// Testbench top of the Morse keyer: clock, reset, character stimulus, settings and verdict.
module tb_morse_character_keyer;
	import mck_pkg::*;

	localparam int NumPhases = 5;
	localparam int ItemsPerPhase = 17;
	localparam int SettleCycles = 64;

	logic                clk;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [DotWidth-1:0] cfg_wr_data;
	int                  fail_count;
	int                  pending;
	int                  idle_pct;
	int                  stall_pct;

	string known_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789+-=.,?/ ";

	mck_char_if chars_if();
	mck_seg_if  segs_if();

	morse_character_keyer u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.chars(chars_if),
		.segments(segs_if),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	mck_segment_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.chars(chars_if),
		.segments(segs_if),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		segs_if.ready <= ($urandom_range(99) >= stall_pct);
	end

	task automatic send_char(input logic [CharWidth-1:0] c);
		while ($urandom_range(99) < idle_pct) begin
			chars_if.valid <= 1'b0;
			@(posedge clk);
		end
		chars_if.valid     <= 1'b1;
		chars_if.character <= c;
		do @(posedge clk); while (!chars_if.ready);
	endtask

	task automatic drain();
		chars_if.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic set_dot_length(input logic [DotWidth-1:0] v);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	initial begin
		logic [DotWidth-1:0] dot_values[NumPhases];
		int                  idle_values[NumPhases];
		int                  stall_values[NumPhases];
		logic [CharWidth-1:0] directed[$];

		arst_n             = 1'b0;
		cfg_wr_en          = 1'b0;
		cfg_wr_data        = '0;
		chars_if.valid     = 1'b0;
		chars_if.character = '0;
		idle_pct           = 0;
		stall_pct          = 0;

		dot_values   = '{11'd1200, 11'd1, 11'd2047, 11'd0, DotWidth'($urandom_range(1, 1200))};
		idle_values  = '{0, 63, 0, 37, 37};
		stall_values = '{0, 0, 63, 37, 37};
		directed = '{" ", "E", "T", "A", "0", ".", ",", "?", "+", "-", "=", "/", "1", "5",
			"9", "Z", "Q", "a", "z", 8'h00, 8'hFF, 8'h7F, "*", "S", " "};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_char(directed[i]);
		drain();

		for (int p = 0; p < NumPhases; p++) begin
			set_dot_length(dot_values[p]);
			idle_pct  = idle_values[p];
			stall_pct = stall_values[p];
			for (int n = 0; n < ItemsPerPhase; n++) begin
				if ($urandom_range(99) < 80)
					send_char(known_chars[$urandom_range(known_chars.len() - 1)]);
				else
					send_char(CharWidth'($urandom_range(255)));
			end
			drain();
		end

		if (fail_count == 0 && pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
